>>> rtl/cdq_pkg.sv
// Shared constants, command and status codes, and control types for the circular deque.
package cdq_pkg;

  // Ring store geometry
  localparam int DEPTH  = 128;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CAP_W  = IDX_W + 1;
  localparam int CFG_W  = 8;
  localparam int CMP_W  = (CFG_W > CAP_W) ? CFG_W : CAP_W;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;

  // Capacity register after reset
  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(128);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_FRONT  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_INS_BACK   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_DEL_BACK   = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = CMD_W'(4);
  localparam logic [CMD_W-1:0] CMD_PEEK_REAR  = CMD_W'(5);

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = ST_W'(0);
  localparam logic [ST_W-1:0] ST_OVERFLOW  = ST_W'(1);
  localparam logic [ST_W-1:0] ST_UNDERFLOW = ST_W'(2);

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch the input beat
    logic rd_en;   // read the peek slot
    logic commit;  // update indices, store and result register
  } cdq_ctl_t;

endpackage

>>> rtl/circular_deque_top.sv
// Top level of the circular deque: controller, datapath and ring store.
//
// Usage:
//   Input channel in_valid/in_stall carries one command beat (in_command,
//   in_value). Result channel out_valid/out_stall returns exactly one beat per
//   command: out_read_value, out_status, out_is_empty, out_is_full.
//   cfg_we/cfg_wdata writes the capacity register; write it only while idle.
// Timing:
//   A command is accepted in S_IDLE, reads its slot from the ring RAM in the
//   next cycle (S_READ), and commits in S_DONE once the result register is
//   free; out_valid is registered from the commit. One command is in flight
//   at a time: the next command is accepted only after the last one commits,
//   set by the registered read of the single ring RAM read port.
// Stall:
//   A pending result is held while out_stall is high; the next command is still
//   accepted and read, then waits at commit until the result register drains.
// Reset:
//   rst_n (synchronous, active low) empties the deque, zeroes both indices and
//   sets capacity to 128. The ring store is not cleared and needs no sweep.
module circular_deque_top
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [ST_W-1:0]          out_status,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  cdq_ctl_t ctl;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  cdq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_command     (in_command),
    .in_value       (in_value),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

endmodule

>>> rtl/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cdq_ctrl.sv
// Sequencer for the circular deque: accept, slot read, commit and result handoff.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output cdq_ctl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Result register may be loaded when empty or drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Commands to the datapath
  always_comb begin
    ctl.load   = (state_r == S_IDLE) && in_valid;
    ctl.rd_en  = (state_r == S_READ);
    ctl.commit = (state_r == S_DONE) && out_free;
  end

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // One beat in flight: an accepted beat blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a command is in flight");

  // A result appears only out of the commit state
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result valid raised outside commit");

endmodule

>>> rtl/cdq_dpath.sv
// Datapath of the circular deque: indices, capacity, ring store and result register.
module cdq_dpath
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cdq_ctl_t                 ctl,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [ST_W-1:0]          out_status,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  // Step an index forward with wrap at the capacity
  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] inc;
    inc = {1'b0, idx} + CAP_W'(1);
    if (inc >= cap) begin
      return '0;
    end
    return inc[IDX_W-1:0];
  endfunction

  // Step an index back with wrap at the capacity; an index at or beyond the capacity lands on the last slot
  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] last;
    last = cap - CAP_W'(1);
    if (idx == '0 || {1'b0, idx} >= cap) begin
      return last[IDX_W-1:0];
    end
    return idx - IDX_W'(1);
  endfunction

  logic [CFG_W-1:0]         cap_r;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [IDX_W-1:0]         tail_r, tail_nxt;
  logic                     empty_r, empty_nxt;
  logic [CMD_W-1:0]         cmd_r;
  logic [DATA_W-1:0]        val_r;
  logic signed [DATA_W-1:0] rv_r;
  logic [DATA_W-1:0]        rv_nxt;
  logic [ST_W-1:0]          st_r, st_nxt;
  logic                     empty_out_r;
  logic                     full_r, full_nxt;

  logic [CMP_W-1:0]  cap_ext;
  logic [CAP_W-1:0]  eff_cap;
  logic              full_now;
  logic              is_insert;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Clamp the capacity register into 1..DEPTH
  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CAP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext[CAP_W-1:0];
    end
  end

  assign full_now  = !empty_r && (step_up(tail_r, eff_cap) == head_r);
  assign is_insert = (cmd_r == CMD_INS_FRONT) || (cmd_r == CMD_INS_BACK);
  assign ram_raddr = (cmd_r == CMD_PEEK_FRONT) ? head_r : tail_r;

  // Command decode and next indices
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    st_nxt    = ST_OK;
    rv_nxt    = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    unique case (cmd_r)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (full_now) begin
          st_nxt = ST_OVERFLOW;
        end else if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          ram_we    = 1'b1;
          ram_waddr = '0;
        end else if (cmd_r == CMD_INS_FRONT) begin
          head_nxt  = step_down(head_r, eff_cap);
          ram_we    = 1'b1;
          ram_waddr = head_nxt;
        end else begin
          tail_nxt  = step_up(tail_r, eff_cap);
          ram_we    = 1'b1;
          ram_waddr = tail_nxt;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (empty_r) begin
          st_nxt = ST_UNDERFLOW;
        end else if (head_r == tail_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b1;
        end else if (cmd_r == CMD_DEL_FRONT) begin
          head_nxt = step_up(head_r, eff_cap);
        end else begin
          tail_nxt = step_down(tail_r, eff_cap);
        end
      end
      CMD_PEEK_FRONT, CMD_PEEK_REAR: begin
        if (empty_r) begin
          st_nxt = ST_UNDERFLOW;
          rv_nxt = '1;
        end else begin
          rv_nxt = ram_rdata;
        end
      end
      default: begin
        st_nxt = ST_OK;
      end
    endcase
    full_nxt = !empty_nxt && (step_up(tail_nxt, eff_cap) == head_nxt);
  end

  // Ring store
  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we && ctl.commit),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (ctl.rd_en),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state: capacity, indices, empty flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (ctl.commit) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        empty_r <= empty_nxt;
      end
    end
  end

  // Input beat and result payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      val_r <= in_value;
    end
    if (ctl.commit) begin
      rv_r        <= rv_nxt;
      st_r        <= st_nxt;
      empty_out_r <= empty_nxt;
      full_r      <= full_nxt;
    end
  end

  assign out_read_value = rv_r;
  assign out_status     = st_r;
  assign out_is_empty   = empty_out_r;
  assign out_is_full    = full_r;

  // An empty deque always parks both indices at slot 0
  a_empty_parks: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0 && tail_r == '0))
    else $error("empty deque with nonzero index");

  // A successful insert leaves the deque non-empty
  a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && is_insert && st_nxt == ST_OK) |=> !empty_r)
    else $error("deque empty after a successful insert");

endmodule
